// ===== hdl/uoi_pkg.sv =====
// Package with shared types and constants for the odometry integrator.
`timescale 1ns / 1ps
package uoi_pkg;

  localparam int AtanLen = 30;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0] RadToBam = 32'd2734261102;

  typedef logic [31:0] angle_t;
  typedef logic signed [33:0] q30_t;

  typedef enum logic [0:0] {
    CMD_SET  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    begin
      r = 32'd0;
      case (idx)
        5'd0: r = 32'd536870912;
        5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;
        5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;
        5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;
        5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;
        5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        5'd28: r = 32'd3;
        5'd29: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/uoi_cordic.sv =====
// Iterative rotation-mode CORDIC giving cosine and sine in Q4.30.
`timescale 1ns / 1ps
module uoi_cordic import uoi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  angle_t angle,
  output logic   done,
  output q30_t   cos_q,
  output q30_t   sin_q
);

  q30_t x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [4:0] i_r, i_nxt;
  logic busy_r, busy_nxt, flip_r, flip_nxt, done_r, done_nxt;
  angle_t a_fold;
  q30_t xs, ys;
  logic signed [32:0] at;

  always_comb begin
    a_fold = angle;
    flip_nxt = flip_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = $signed({1'b0, atan_bam(i_r)});
    if (start) begin
      flip_nxt = 1'b0;
      if (angle[31] ^ angle[30]) begin
        a_fold = angle - 32'h8000_0000;
        flip_nxt = 1'b1;
      end
      x_nxt = CordicGain;
      y_nxt = '0;
      z_nxt = {a_fold[31], a_fold};
      i_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    flip_r <= flip_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done  = done_r;
  assign cos_q = flip_r ? -x_r : x_r;
  assign sin_q = flip_r ? -y_r : y_r;

endmodule

// ===== hdl/unicycle_odometry_integrator_core.sv =====
// Top level of the unicycle dead-reckoning odometry integrator.
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    command, speed, turn rate
//   out_     output     out_valid/out_ready  pose, quaternion, velocities
//   cfg_     input      cfg_valid/cfg_ready  step time
// A velocity transfer is stored straight from idle; a tick runs the shared CORDIC
// once for the old heading and once for half the new, with the multiply states between.
// One multiplier is reused in turn for the step, position and turn products; a second scales the heading.
// Reset is synchronous and active low, and clears the pose and velocities.
// The result sits in an output register; in_ready is low until it is taken.
`timescale 1ns / 1ps
module unicycle_odometry_integrator_core import uoi_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [15:0] in_linear_speed_in,
  input  logic signed [15:0] in_turn_rate_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic [31:0]        out_heading_angle,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic signed [15:0] out_linear_speed_out,
  output logic signed [15:0] out_turn_rate_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_step_time
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CORD1 = 10'b0000000010,
    S_MULP  = 10'b0000000100,
    S_MULX  = 10'b0000001000,
    S_MULY  = 10'b0000010000,
    S_MULW  = 10'b0000100000,
    S_MULH  = 10'b0001000000,
    S_HEAD  = 10'b0010000000,
    S_CORD2 = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] step_r;
  logic signed [31:0] x_r, y_r;
  logic [31:0] h_r;
  logic signed [15:0] v_r, w_r;
  logic signed [31:0] p_r;
  logic [47:0] m_r;
  q30_t c_r, s_r;
  logic go_r;
  logic cdone;
  q30_t ccos, csin;
  angle_t cang;
  logic signed [63:0] prod;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic [15:0] wmag;
  logic [79:0] hprod;
  logic [31:0] delta;
  logic signed [15:0] qz, qw;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [63:0] d);
    logic signed [33:0] s;
    begin
      s = 34'(a) + 34'(d);
      if (s > 34'sd2147483647) return 32'sh7fff_ffff;
      if (s < -34'sd2147483648) return 32'sh8000_0000;
      return s[31:0];
    end
  endfunction

  function automatic logic signed [15:0] to_q14(input q30_t q);
    logic signed [34:0] t;
    logic signed [18:0] r;
    begin
      t = 35'(q) + 35'sd32768;
      r = t[34:16];
      if (r > 19'sd16384) return 16'sd16384;
      if (r < -19'sd16384) return -16'sd16384;
      return r[15:0];
    end
  endfunction

  assign cang = (state_r == S_CORD2) ? {1'b0, h_r[31:1]} : h_r;

  uoi_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(go_r), .angle(cang),
    .done(cdone), .cos_q(ccos), .sin_q(csin)
  );

  assign wmag = w_r[15] ? 16'(-w_r) : w_r;

  always_comb begin
    mul_a = 34'(v_r);
    mul_b = 33'($signed({1'b0, step_r}));
    unique case (state_r)
      S_MULX: begin mul_a = c_r; mul_b = 33'(p_r); end
      S_MULY: begin mul_a = s_r; mul_b = 33'(p_r); end
      S_MULW: begin mul_a = $signed({18'd0, wmag}); end
      default: ;
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
  end

  assign hprod = 80'(m_r) * 80'(RadToBam) + (80'(1) << 29);
  assign delta = hprod[61:30];
  assign in_ready = (state_r == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid && in_ready && in_command == CMD_TICK) state_nxt = S_CORD1;
      S_CORD1: if (cdone) state_nxt = S_MULP;
      S_MULP:  state_nxt = S_MULX;
      S_MULX:  state_nxt = S_MULY;
      S_MULY:  state_nxt = S_MULW;
      S_MULW:  state_nxt = S_MULH;
      S_MULH:  state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_CORD2;
      S_CORD2: if (cdone) state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign qz = to_q14(csin);
  assign qw = to_q14(ccos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= 16'd2185;
      x_r <= '0;
      y_r <= '0;
      h_r <= '0;
      v_r <= '0;
      w_r <= '0;
      go_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r <= 1'b0;
      if (cfg_valid && cfg_ready) step_r <= cfg_step_time;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (in_command == CMD_SET) begin
              v_r <= in_linear_speed_in;
              w_r <= in_turn_rate_in;
            end else begin
              go_r <= 1'b1;
            end
          end
        end
        S_CORD1: if (cdone) begin c_r <= ccos; s_r <= csin; end
        S_MULP: p_r <= prod[31:0];
        S_MULX: x_r <= sat_add(x_r, (prod + (64'sd1 <<< 37)) >>> 38);
        S_MULY: y_r <= sat_add(y_r, (prod + (64'sd1 <<< 37)) >>> 38);
        S_MULW: m_r <= prod[47:0];
        S_MULH: h_r <= w_r[15] ? h_r - delta : h_r + delta;
        S_HEAD: go_r <= 1'b1;
        S_CORD2: if (cdone) begin
          out_valid <= 1'b1;
          out_quat_z <= qz;
          out_quat_w <= qw;
        end
        default: ;
      endcase
    end
  end

  assign out_pos_x = x_r;
  assign out_pos_y = y_r;
  assign out_heading_angle = h_r;
  assign out_linear_speed_out = v_r;
  assign out_turn_rate_out = w_r;

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_out_from_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_CORD2) else $error("stray result");
  a_held_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x)) else $error("result lost");
`endif

endmodule

// ===== dv/unicycle_odometry_integrator_core_test.sv =====
// Self-checking testbench for the unicycle odometry integrator core.
`timescale 1ns / 1ps
module unicycle_odometry_integrator_core_test;
  import uoi_pkg::*;

  localparam int Steps = 16;
  localparam int SettleCycles = 60;
  localparam longint GainQ30 = 64'sd652032874;
  localparam longint unsigned BamPerRad = 64'd2734261102;
  localparam longint ArcTab [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hd;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic signed [15:0] lv;
    logic signed [15:0] tr;
  } pose_report_t;

  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] lin;
    logic signed [15:0] turn;
    bit                 zero_pose;
    bit                 vel_known;
  } drive_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_command = 1'b0;
  logic signed [15:0] in_linear_speed_in = '0;
  logic signed [15:0] in_turn_rate_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic [31:0]        out_heading_angle;
  logic signed [15:0] out_quat_z;
  logic signed [15:0] out_quat_w;
  logic signed [15:0] out_linear_speed_out;
  logic signed [15:0] out_turn_rate_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_step_time = '0;

  unicycle_odometry_integrator_core #(.CORDIC_STEPS(Steps)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_linear_speed_in(in_linear_speed_in), .in_turn_rate_in(in_turn_rate_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_heading_angle(out_heading_angle),
    .out_quat_z(out_quat_z), .out_quat_w(out_quat_w),
    .out_linear_speed_out(out_linear_speed_out),
    .out_turn_rate_out(out_turn_rate_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_step_time(cfg_step_time)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0]        dt_model;
  logic [31:0]        x_model;
  logic [31:0]        y_model;
  logic [31:0]        hd_model;
  logic signed [15:0] lin_model;
  logic signed [15:0] turn_model;
  pose_report_t       pose_reports_due[$];
  int                 mismatch_count = 0;
  bit                 hold_request = 1'b0;

  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a;
    logic [31:0] probe;
    bit          flip;
    longint      x, y, z, xs, ys;
    a = ang;
    probe = a + 32'h4000_0000;
    flip = probe[31];
    if (flip) a = a - 32'h8000_0000;
    x = GainQ30;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < Steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ArcTab[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ArcTab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] clamp_add(input logic [31:0] acc, input longint d);
    longint t;
    t = longint'($signed(acc)) + d;
    if (t > 64'sd2147483647) t = 64'sd2147483647;
    if (t < -64'sd2147483648) t = -64'sd2147483648;
    return t[31:0];
  endfunction

  function automatic logic signed [15:0] half_angle_q14(input longint q30);
    longint r;
    r = (q30 + 32768) >>> 16;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic pose_report_t advance_pose();
    longint            c, s, p, dx, dy;
    longint unsigned   mag, delta;
    pose_report_t      r;
    rotate_unit(hd_model, c, s);
    p = longint'(lin_model) * longint'(dt_model);
    dx = (p * c + 64'sd137438953472) >>> 38;
    dy = (p * s + 64'sd137438953472) >>> 38;
    x_model = clamp_add(x_model, dx);
    y_model = clamp_add(y_model, dy);
    mag = (turn_model < 0) ? longint'(-longint'(turn_model)) : longint'(turn_model);
    delta = (mag * longint'(dt_model) * BamPerRad + 64'd536870912) >> 30;
    if (turn_model < 0) hd_model = hd_model - delta[31:0];
    else hd_model = hd_model + delta[31:0];
    rotate_unit(hd_model >> 1, c, s);
    r.px = x_model;
    r.py = y_model;
    r.hd = hd_model;
    r.qz = half_angle_q14(s);
    r.qw = half_angle_q14(c);
    r.lv = lin_model;
    r.tr = turn_model;
    return r;
  endfunction

  task automatic offer(input cmd_t cmd, input logic signed [15:0] lin,
                       input logic signed [15:0] turn, input bit zero_pose,
                       input bit vel_known, input bit no_gap);
    int           gap;
    int           roll;
    pose_report_t r;
    roll = $urandom_range(0, 99);
    if (no_gap || roll < 60) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_linear_speed_in <= lin;
    in_turn_rate_in <= turn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_SET) begin
      lin_model = lin;
      turn_model = turn;
    end else begin
      r = advance_pose();
      if (zero_pose) begin
        r.px = '0; r.py = '0; r.hd = '0;
      end
      if (vel_known) begin
        r.lv = lin_model; r.tr = turn_model;
      end
      pose_reports_due.push_back(r);
    end
  endtask

  task automatic write_step_time(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_step_time <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dt_model = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pose_reports_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_item(input int bias);
    logic signed [15:0] lin;
    logic signed [15:0] turn;
    int                 roll;
    roll = $urandom_range(0, 99);
    lin = 16'($urandom);
    turn = 16'($urandom);
    if (bias != 0) begin
      if ($urandom_range(0, 9) != 0) lin = 16'(bias);
      if ($urandom_range(0, 4) != 0) turn = '0;
      if (roll < 5) offer(CMD_SET, lin, turn, 1'b0, 1'b0, 1'b0);
      else offer(CMD_TICK, lin, turn, 1'b0, 1'b0, 1'b0);
    end else begin
      if (roll < 30) offer(CMD_SET, lin, turn, 1'b0, 1'b0, 1'b0);
      else offer(CMD_TICK, lin, turn, 1'b0, 1'b0, 1'b0);
    end
  endtask

  always begin
    int hold_left;
    int burst_left;
    int roll;
    pose_report_t got;
    pose_report_t want;
    hold_left = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got = '{out_pos_x, out_pos_y, out_heading_angle, out_quat_z, out_quat_w,
                out_linear_speed_out, out_turn_rate_out};
        if (pose_reports_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result transfer: %h", got);
        end else begin
          want = pose_reports_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch: expected x=%0d y=%0d hd=%h qz=%0d qw=%0d v=%0d w=%0d",
                       want.px, want.py, want.hd, want.qz, want.qw, want.lv, want.tr);
              $display("          actual   x=%0d y=%0d hd=%h qz=%0d qw=%0d v=%0d w=%0d",
                       got.px, got.py, got.hd, got.qz, got.qw, got.lv, got.tr);
            end
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      roll = $urandom_range(0, 999);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready <= 1'b1;
      end else begin
        if (roll < 15) burst_left = 60;
        else if (roll < 20) hold_left = $urandom_range(30, 150);
        out_ready <= (roll % 10) >= 3;
      end
    end
  end

  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    drive_row_t rows[$];
    logic [15:0] step_plan[5];
    int          count_plan[5];
    int          bias_plan[5];
    rows = '{
      '{CMD_TICK, 16'sh7fff, -16'sh8000, 1'b1, 1'b1},
      '{CMD_SET,  16'sh7fff, 16'sh0000, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_TICK, -16'sh8000, 16'sh7fff, 1'b0, 1'b1},
      '{CMD_SET,  -16'sh8000, 16'sh7fff, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_TICK, 16'sh1234, 16'sh4321, 1'b0, 1'b1},
      '{CMD_SET,  16'sh0000, -16'sh8000, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_SET,  -16'sh0001, -16'sh0001, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_SET,  16'sh0001, 16'sh0001, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_SET,  16'sh0100, 16'sh1000, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_SET,  16'sh5555, -16'sh5556, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1},
      '{CMD_SET,  -16'sh5556, 16'sh5555, 1'b0, 1'b0},
      '{CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b1}
    };
    step_plan = '{16'd0, 16'd65535, 16'd65535, 16'd1, 16'd0};
    step_plan[4] = 16'($urandom_range(2, 65534));
    count_plan = '{40, 280, 250, 100, 260};
    bias_plan = '{0, 32767, -32768, 0, 0};
    dt_model = 16'd2185;
    x_model = '0;
    y_model = '0;
    hd_model = '0;
    lin_model = '0;
    turn_model = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      offer(rows[i].cmd, rows[i].lin, rows[i].turn, rows[i].zero_pose, rows[i].vel_known, 1'b0);
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_step_time(step_plan[ph]);
      if (bias_plan[ph] != 0)
        offer(CMD_SET, 16'(bias_plan[ph]), 16'sh0000, 1'b0, 1'b0, 1'b0);
      if (ph == 4) begin
        hold_request = 1'b1;
        for (int k = 0; k < 12; k++)
          offer(CMD_TICK, 16'sh0000, 16'sh0000, 1'b0, 1'b0, 1'b1);
      end
      for (int k = 0; k < count_plan[ph]; k++) random_item(bias_plan[ph]);
    end
    drain();
    if (mismatch_count == 0 && pose_reports_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
